// ----- rtl/core/rtd_pkg.sv -----
package rtd_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 7;
    localparam int TOTAL_W  = 16;
    localparam int CFG_W    = 16;

    // packet length counter width (8 to 32)
    localparam int LEN_BITS = 16;
    localparam int CMP_W    = ((LEN_BITS > CFG_W) ? LEN_BITS : CFG_W) + 1;

    // tag byte layout: top bit flags a run, the rest is the count
    localparam int          RUN_BIT    = BYTE_W - 1;
    localparam logic [CNT_W-1:0] COUNT_MASK = {CNT_W{1'b1}};

    // result queue
    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_TAG     = 2'd0,
        PH_RUNVAL  = 2'd1,
        PH_LIT     = 2'd2,
        PH_DISCARD = 2'd3
    } t_phase;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  out_byte;
        logic [CNT_W-1:0]   repeat_res;
        logic [TOTAL_W-1:0] total_len;
        logic               last;
    } t_res;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] num;
        t_res       res0;
        t_res       res1;
    } t_push;

    function automatic t_res mk_data(input logic [BYTE_W-1:0] b,
                                     input logic [CNT_W-1:0] rep);
        t_res r;
        r.kind       = KIND_DATA;
        r.out_byte   = b;
        r.repeat_res = rep;
        r.total_len  = '0;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic t_res mk_ok(input logic [LEN_BITS-1:0] len);
        t_res r;
        r.kind       = KIND_OK;
        r.out_byte   = '0;
        r.repeat_res = '0;
        r.total_len  = TOTAL_W'(len);
        r.last       = 1'b1;
        return r;
    endfunction

    function automatic t_res mk_err();
        t_res r;
        r.kind       = KIND_ERR;
        r.out_byte   = '0;
        r.repeat_res = '0;
        r.total_len  = '0;
        r.last       = 1'b1;
        return r;
    endfunction

endpackage

// ----- rtl/core/rtd_if.sv -----
// compressed byte channel
interface rtd_in_if import rtd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_packet;

    modport source(output valid, output in_byte, output end_of_packet, input ready);
    modport sink(input valid, input in_byte, input end_of_packet, output ready);
endinterface

// decoded item channel
interface rtd_out_if import rtd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [BYTE_W-1:0]  out_byte;
    logic [CNT_W-1:0]   repeat_res;
    logic [TOTAL_W-1:0] total_len;
    logic               last;

    modport source(output valid, output kind, output out_byte, output repeat_res,
                   output total_len, output last, input ready);
    modport sink(input valid, input kind, input out_byte, input repeat_res,
                 input total_len, input last, output ready);
endinterface

// ----- rtl/core/rtd_decode.sv -----
module rtd_decode import rtd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_in_eop,
    output logic              o_in_ready,
    input  logic [CFG_W-1:0]  i_max_len,
    input  logic              i_room2,
    output t_push             o_push
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eop;
    t_phase            r_phase,   n_phase;
    logic [CNT_W-1:0]  r_pend,    n_pend;
    logic [LEN_BITS-1:0] r_wlen,  n_wlen;

    logic              fire;
    logic [CNT_W-1:0]  tag_cnt;
    logic [CNT_W-1:0]  chk_cnt;
    logic [CMP_W-1:0]  sum;
    logic              too_long;
    logic [LEN_BITS-1:0] wlen_add;
    logic [CNT_W-1:0]  pend_dec;
    t_push             push;

    // the held byte is decoded once the queue has room for two results
    assign fire       = r_in_valid && i_room2;
    assign o_in_ready = !r_in_valid || i_room2;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_eop  <= i_in_eop;
        end
    end

    // limit check: literal count at the tag, run count at the value byte
    assign tag_cnt  = r_in_byte[CNT_W-1:0] & COUNT_MASK;
    assign chk_cnt  = (r_phase == PH_TAG) ? tag_cnt : r_pend;
    assign sum      = CMP_W'(r_wlen) + CMP_W'(chk_cnt);
    assign too_long = sum > CMP_W'(i_max_len);
    assign wlen_add = r_wlen + LEN_BITS'((r_phase == PH_LIT) ? CNT_W'(1) : r_pend);
    assign pend_dec = r_pend - CNT_W'(1);

    // next state and results
    always_comb begin
        n_phase   = r_phase;
        n_pend    = r_pend;
        n_wlen    = r_wlen;
        push.num  = 2'd0;
        push.res0 = mk_err();
        push.res1 = mk_err();
        unique case (r_phase)
            PH_TAG: begin
                if (r_in_byte[RUN_BIT]) begin
                    if (r_in_eop) begin
                        push.num = 2'd1;
                        n_pend   = '0;
                        n_wlen   = '0;
                    end else begin
                        n_pend  = tag_cnt;
                        n_phase = PH_RUNVAL;
                    end
                end else if (tag_cnt == '0) begin
                    if (r_in_eop) begin
                        push.num  = 2'd1;
                        push.res0 = mk_ok(r_wlen);
                        n_pend    = '0;
                        n_wlen    = '0;
                    end
                end else if (r_in_eop || too_long) begin
                    push.num = 2'd1;
                    n_pend   = '0;
                    n_wlen   = '0;
                    n_phase  = r_in_eop ? PH_TAG : PH_DISCARD;
                end else begin
                    n_pend  = tag_cnt;
                    n_phase = PH_LIT;
                end
            end
            PH_RUNVAL: begin
                n_pend  = '0;
                n_phase = PH_TAG;
                if (r_pend == '0) begin
                    if (r_in_eop) begin
                        push.num  = 2'd1;
                        push.res0 = mk_ok(r_wlen);
                        n_wlen    = '0;
                    end
                end else if (too_long) begin
                    push.num = 2'd1;
                    n_wlen   = '0;
                    n_phase  = r_in_eop ? PH_TAG : PH_DISCARD;
                end else begin
                    push.res0 = mk_data(r_in_byte, r_pend);
                    if (r_in_eop) begin
                        push.num  = 2'd2;
                        push.res1 = mk_ok(wlen_add);
                        n_wlen    = '0;
                    end else begin
                        push.num = 2'd1;
                        n_wlen   = wlen_add;
                    end
                end
            end
            PH_LIT: begin
                push.res0 = mk_data(r_in_byte, CNT_W'(1));
                if (r_in_eop) begin
                    push.num = 2'd2;
                    n_pend   = '0;
                    n_wlen   = '0;
                    n_phase  = PH_TAG;
                    // span complete closes ok, otherwise truncated
                    push.res1 = (pend_dec == '0) ? mk_ok(wlen_add) : mk_err();
                end else begin
                    push.num = 2'd1;
                    n_wlen   = wlen_add;
                    n_pend   = pend_dec;
                    if (pend_dec == '0) begin
                        n_phase = PH_TAG;
                    end
                end
            end
            PH_DISCARD: begin
                if (r_in_eop) begin
                    n_phase = PH_TAG;
                    n_pend  = '0;
                    n_wlen  = '0;
                end
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase
    end

    always_comb begin
        o_push     = push;
        o_push.num = fire ? push.num : 2'd0;
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_pend  <= '0;
            r_wlen  <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_wlen  <= n_wlen;
        end
    end

`ifndef ASSERT_OFF
    // discarded bytes give nothing
    a_discard_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DISCARD) |-> (o_push.num == 2'd0))
        else $error("result produced while discarding");
    // a second result always closes the packet
    a_second_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.num == 2'd2) |-> (o_push.res1.last && r_in_eop))
        else $error("second result is not an end item");
    // a literal span is only open with bytes still due
    a_lit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LIT) |-> (r_pend != '0))
        else $error("literal phase with nothing pending");
`endif

endmodule

// ----- rtl/core/rtd_res_fifo.sv -----
module rtd_res_fifo import rtd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room2,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_res
);

    t_res              r_mem [QDEPTH];
    logic [QIDX_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_room2 = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign o_res   = r_mem[r_rd];

    // storage: one or two writes, one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr + QIDX_W'(1)] <= i_push.res1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QIDX_W'(i_push.num);
            if (pop) begin
                r_rd <= r_rd + QIDX_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push.num) - QCNT_W'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");
    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> o_room2)
        else $error("push without room");
    a_push_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != 2'd3)
        else $error("illegal push count");
`endif

endmodule

// ----- rtl/core/rle_tag_stream_decoder.sv -----
// Run-length decoder for tagged compressed packets.
// i_in carries one compressed byte per transfer with end_of_packet on the
// last byte of a packet. o_out carries decoded items: data items (a byte and
// a repeat count of 1 for literals, 1 to 127 for runs, expanded downstream)
// and one end item per packet, ok with the decompressed length or error.
// i_cfg_we / i_cfg_wdata set the per-packet output length limit; write it
// only while no packet is in flight.
// A byte taken on i_in passes the input register, then the result queue,
// before its first item shows on o_out. Throughput is one byte per cycle
// while the queue has room for two items; a byte that yields two items (data
// plus end) is absorbed by a four-entry result queue. i_in.ready is low only
// while the queue cannot take two more items.
// Reset clears the decoder to expect a tag, zeroes the length count,
// empties the queue and sets the limit to 65535. A stalled receiver holds
// o_out steady; the queue then fills and backpressures i_in.
module rle_tag_stream_decoder import rtd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    rtd_in_if.sink           i_in,
    rtd_out_if.source        o_out
);

    logic [CFG_W-1:0] r_max_len;
    t_push            push;
    logic             room2;
    t_res             res;

    // length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= {CFG_W{1'b1}};
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    rtd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_byte  (i_in.in_byte),
        .i_in_eop   (i_in.end_of_packet),
        .o_in_ready (i_in.ready),
        .i_max_len  (r_max_len),
        .i_room2    (room2),
        .o_push     (push)
    );

    rtd_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    // output payload
    assign o_out.kind       = res.kind;
    assign o_out.out_byte   = res.out_byte;
    assign o_out.repeat_res = res.repeat_res;
    assign o_out.total_len  = res.total_len;
    assign o_out.last       = res.last;

endmodule
